// ===== hdl/shgov_pkg.sv =====
// Types, constants and codes of the secondary core hotplug governor.
// Used by shgov_ctrl, shgov_dp and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package shgov_pkg;

    // Field widths
    localparam int CNT_W      = 64;   // cumulative counter width, 32 to 64
    localparam int DLT_W      = 32;   // counter deltas are cut to this width
    localparam int FREQ_W     = 22;
    localparam int PCT_W      = 7;
    localparam int ACT_W      = 2;
    localparam int OP_W       = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 22;

    // Load arithmetic: (dw - di) * 100 needs DLT_W + 7 bits
    localparam int NUM_W      = DLT_W + PCT_W;
    localparam int QBIT_W     = 3;    // indexes the PCT_W quotient bits
    localparam logic [QBIT_W-1:0] QUOT_MSB   = QBIT_W'(PCT_W - 1);
    localparam logic [PCT_W-1:0]  LOAD_SCALE = PCT_W'(100);

    // Register reset values
    localparam logic [PCT_W-1:0]  RST_LOAD_HIGH = PCT_W'(50);
    localparam logic [FREQ_W-1:0] RST_FREQ_LOW  = FREQ_W'(200 * 1000);
    localparam logic [FREQ_W-1:0] RST_FREQ_HIGH = FREQ_W'(500 * 1000);

    typedef enum logic [OP_W-1:0] {
        OP_SAMPLE     = 3'd0,
        OP_SCREEN_OFF = 3'd1,
        OP_SCREEN_ON  = 3'd2,
        OP_SUSPEND    = 3'd3,
        OP_RESUME     = 3'd4,
        OP_REBOOT     = 3'd5
    } t_op;

    typedef enum logic [ACT_W-1:0] {
        ACT_NONE    = 2'd0,
        ACT_OFFLINE = 2'd1,
        ACT_ONLINE  = 2'd2
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LOAD_HIGH   = 2'd0,
        CFG_MANUAL_LOCK = 2'd1,
        CFG_FREQ_LOW    = 2'd2,
        CFG_FREQ_HIGH   = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_MUL,
        S_DIV,
        S_FIN,
        S_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic latch_in;   // capture the request payload
        logic eval;       // decide, update flags, take counter deltas
        logic mul;        // negative delta check, scale numerator by 100
        logic div_step;   // one restoring division step
        logic finish;     // threshold compare on the load
        logic load_out;   // copy the result into the output register
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic need_div;   // sample that computes a load
        logic neg_delta;  // wall delta below idle delta
        logic div_last;   // last quotient bit in progress
    } t_dp_status;

endpackage

`default_nettype wire

// ===== hdl/shgov_dp.sv =====
// Datapath of the hotplug governor: configuration, lock and history state,
// counter deltas, bit-serial load division and the output register.
// Depends on shgov_pkg.
`timescale 1ns / 1ps
`default_nettype none

module shgov_dp (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire shgov_pkg::t_dp_cmd                  i_cmd,
    output shgov_pkg::t_dp_status                    o_status,
    input  wire logic                                i_cfg_we,
    input  wire logic [shgov_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [shgov_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire logic [shgov_pkg::OP_W-1:0]          i_op,
    input  wire logic [shgov_pkg::FREQ_W-1:0]        i_cur_freq_khz,
    input  wire logic                                i_core1_online,
    input  wire logic [63:0]                         i_core0_idle_us,
    input  wire logic [63:0]                         i_core0_wall_us,
    output logic [shgov_pkg::ACT_W-1:0]              o_action,
    output logic                                     o_reschedule,
    output logic                                     o_long_delay,
    output logic [shgov_pkg::PCT_W-1:0]              o_load_pct
);

    // Configuration and history state (reset)
    logic [shgov_pkg::PCT_W-1:0]  r_load_high, n_load_high;
    logic                         r_manual, n_manual;
    logic [shgov_pkg::FREQ_W-1:0] r_freq_low, n_freq_low;
    logic [shgov_pkg::FREQ_W-1:0] r_freq_high, n_freq_high;
    logic [shgov_pkg::FREQ_W-1:0] r_prev_freq, n_prev_freq;
    logic [shgov_pkg::CNT_W-1:0]  r_prev_idle, n_prev_idle;
    logic [shgov_pkg::CNT_W-1:0]  r_prev_wall, n_prev_wall;
    logic                         r_screen_off, n_screen_off;
    logic                         r_susp, n_susp;
    logic                         r_reboot, n_reboot;
    logic                         r_delay_long, n_delay_long;

    // Request payload and work registers (no reset, except r_bit)
    shgov_pkg::t_op               r_op;
    logic [shgov_pkg::FREQ_W-1:0] r_freq;
    logic                         r_online;
    logic [shgov_pkg::CNT_W-1:0]  r_idle;
    logic [shgov_pkg::CNT_W-1:0]  r_wall;
    logic [shgov_pkg::DLT_W-1:0]  r_di, n_di;
    logic [shgov_pkg::DLT_W-1:0]  r_dw, n_dw;
    logic [shgov_pkg::NUM_W-1:0]  r_rem, n_rem;
    logic [shgov_pkg::PCT_W-1:0]  r_quot, n_quot;
    logic [shgov_pkg::QBIT_W-1:0] r_bit, n_bit;
    shgov_pkg::t_action           r_act, n_act;
    logic                         r_resched, n_resched;
    logic [shgov_pkg::PCT_W-1:0]  r_load, n_load;

    logic                         locked;
    logic                         low2;
    logic                         high2;
    logic                         skip;
    logic [shgov_pkg::CNT_W-1:0]  d_idle;
    logic [shgov_pkg::CNT_W-1:0]  d_wall;
    logic [shgov_pkg::DLT_W-1:0]  diff;
    logic [shgov_pkg::NUM_W-1:0]  trial;
    logic                         div_take;

    // Decision terms from the captured request
    assign locked = r_manual | r_susp | r_reboot;
    assign low2   = (r_freq <= r_freq_low) && (r_prev_freq <= r_freq_low);
    assign high2  = (r_freq > r_freq_high) && (r_prev_freq > r_freq_high);
    assign skip   = r_screen_off && !r_online;
    assign d_idle = r_idle - r_prev_idle;
    assign d_wall = r_wall - r_prev_wall;
    assign diff   = r_dw - r_di;
    assign trial  = shgov_pkg::NUM_W'(r_dw) << r_bit;
    // a zero wall delta leaves the quotient at zero
    assign div_take = (r_dw != '0) && (r_rem >= trial);

    assign o_status.need_div  = (r_op == shgov_pkg::OP_SAMPLE) && !skip && !locked
                                && !low2 && high2 && !r_online;
    assign o_status.neg_delta = r_dw < r_di;
    assign o_status.div_last  = r_bit == '0;

    // Next state
    always_comb begin
        n_load_high  = r_load_high;
        n_manual     = r_manual;
        n_freq_low   = r_freq_low;
        n_freq_high  = r_freq_high;
        n_prev_freq  = r_prev_freq;
        n_prev_idle  = r_prev_idle;
        n_prev_wall  = r_prev_wall;
        n_screen_off = r_screen_off;
        n_susp       = r_susp;
        n_reboot     = r_reboot;
        n_delay_long = r_delay_long;
        n_di         = r_di;
        n_dw         = r_dw;
        n_rem        = r_rem;
        n_quot       = r_quot;
        n_bit        = r_bit;
        n_act        = r_act;
        n_resched    = r_resched;
        n_load       = r_load;

        // the user must write configuration only while idle; the block does not enforce it
        if (i_cfg_we) begin
            case (shgov_pkg::t_cfg_idx'(i_cfg_index))
                shgov_pkg::CFG_LOAD_HIGH:   n_load_high = i_cfg_data[shgov_pkg::PCT_W-1:0];
                shgov_pkg::CFG_MANUAL_LOCK: n_manual    = i_cfg_data[0];
                shgov_pkg::CFG_FREQ_LOW:    n_freq_low  = i_cfg_data[shgov_pkg::FREQ_W-1:0];
                shgov_pkg::CFG_FREQ_HIGH:   n_freq_high = i_cfg_data[shgov_pkg::FREQ_W-1:0];
                default: ;
            endcase
        end

        // decision step
        if (i_cmd.eval) begin
            n_act     = shgov_pkg::ACT_NONE;
            n_resched = 1'b0;
            n_load    = '0;
            case (r_op)
                shgov_pkg::OP_SAMPLE: begin
                    if (!skip) begin
                        n_resched   = 1'b1;
                        n_prev_freq = r_freq;
                        if (!locked) begin
                            if (low2) begin
                                n_act        = r_online ? shgov_pkg::ACT_OFFLINE
                                                        : shgov_pkg::ACT_NONE;
                                n_delay_long = 1'b0;
                            end else if (high2) begin
                                if (!r_online) begin
                                    n_prev_idle = r_idle;
                                    n_prev_wall = r_wall;
                                    n_di        = d_idle[shgov_pkg::DLT_W-1:0];
                                    n_dw        = d_wall[shgov_pkg::DLT_W-1:0];
                                end
                            end else begin
                                n_delay_long = r_online;
                            end
                        end
                    end
                end
                shgov_pkg::OP_SCREEN_OFF: n_screen_off = 1'b1;
                shgov_pkg::OP_SCREEN_ON: begin
                    n_screen_off = 1'b0;
                    n_resched    = 1'b1;
                end
                shgov_pkg::OP_SUSPEND: n_susp   = 1'b1;
                shgov_pkg::OP_RESUME:  n_susp   = 1'b0;
                shgov_pkg::OP_REBOOT:  n_reboot = 1'b1;
                default: ;
            endcase
        end

        // negative delta aborts, otherwise scale the busy time by 100
        if (i_cmd.mul) begin
            if (r_dw < r_di) begin
                n_delay_long = 1'b0;
            end else begin
                n_rem  = shgov_pkg::NUM_W'(diff) * shgov_pkg::NUM_W'(shgov_pkg::LOAD_SCALE);
                n_quot = '0;
                n_bit  = shgov_pkg::QUOT_MSB;
            end
        end

        // restoring division, one quotient bit per cycle
        if (i_cmd.div_step) begin
            if (div_take) begin
                n_rem         = r_rem - trial;
                n_quot[r_bit] = 1'b1;
            end
            n_bit = r_bit - 1'b1;
        end

        // threshold compare
        if (i_cmd.finish) begin
            n_load = r_quot;
            if (r_quot > r_load_high) begin
                n_act        = shgov_pkg::ACT_ONLINE;
                n_delay_long = 1'b1;
            end else begin
                n_delay_long = 1'b0;
            end
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_high  <= shgov_pkg::RST_LOAD_HIGH;
            r_manual     <= 1'b0;
            r_freq_low   <= shgov_pkg::RST_FREQ_LOW;
            r_freq_high  <= shgov_pkg::RST_FREQ_HIGH;
            r_prev_freq  <= '0;
            r_prev_idle  <= '0;
            r_prev_wall  <= '0;
            r_screen_off <= 1'b0;
            r_susp       <= 1'b0;
            r_reboot     <= 1'b0;
            r_delay_long <= 1'b0;
            r_bit        <= '0;
        end else begin
            r_load_high  <= n_load_high;
            r_manual     <= n_manual;
            r_freq_low   <= n_freq_low;
            r_freq_high  <= n_freq_high;
            r_prev_freq  <= n_prev_freq;
            r_prev_idle  <= n_prev_idle;
            r_prev_wall  <= n_prev_wall;
            r_screen_off <= n_screen_off;
            r_susp       <= n_susp;
            r_reboot     <= n_reboot;
            r_delay_long <= n_delay_long;
            r_bit        <= n_bit;
        end
    end

    // Payload and work registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_op     <= shgov_pkg::t_op'(i_op);
            r_freq   <= i_cur_freq_khz;
            r_online <= i_core1_online;
            r_idle   <= i_core0_idle_us[shgov_pkg::CNT_W-1:0];
            r_wall   <= i_core0_wall_us[shgov_pkg::CNT_W-1:0];
        end
        r_di      <= n_di;
        r_dw      <= n_dw;
        r_rem     <= n_rem;
        r_quot    <= n_quot;
        r_act     <= n_act;
        r_resched <= n_resched;
        r_load    <= n_load;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_action     <= r_act;
            o_reschedule <= r_resched;
            o_long_delay <= r_delay_long;
            o_load_pct   <= r_load;
        end
    end

    // Quotient of (dw - di) * 100 / dw never exceeds 100
    a_load_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |-> r_quot <= shgov_pkg::LOAD_SCALE)
        else $error("load quotient above 100");

    // Reboot lock is sticky until reset
    a_reboot_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_reboot |=> r_reboot)
        else $error("reboot lock cleared");

endmodule

`default_nettype wire

// ===== hdl/shgov_ctrl.sv =====
// Sequencer of the hotplug governor: request handshake, step commands to
// the datapath and the output valid flag. Depends on shgov_pkg.
`timescale 1ns / 1ps
`default_nettype none

module shgov_ctrl (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    input  wire shgov_pkg::t_dp_status  i_status,
    output shgov_pkg::t_dp_cmd          o_cmd
);

    shgov_pkg::t_state r_state, n_state;
    logic              r_out_valid, n_out_valid;

    assign o_out_valid = r_out_valid;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= shgov_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        case (r_state)
            shgov_pkg::S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.latch_in = i_in_valid;
                if (i_in_valid) begin
                    n_state = shgov_pkg::S_EVAL;
                end
            end
            shgov_pkg::S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = i_status.need_div ? shgov_pkg::S_MUL : shgov_pkg::S_DONE;
            end
            shgov_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = i_status.neg_delta ? shgov_pkg::S_DONE : shgov_pkg::S_DIV;
            end
            shgov_pkg::S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_last) begin
                    n_state = shgov_pkg::S_FIN;
                end
            end
            shgov_pkg::S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state      = shgov_pkg::S_DONE;
            end
            shgov_pkg::S_DONE: begin
                // hand over once the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = shgov_pkg::S_IDLE;
                end
            end
            default: n_state = shgov_pkg::S_IDLE;
        endcase
    end

    // A pending result is never overwritten
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("output register overwritten");

    // A loaded result shows valid on the next cycle
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> r_out_valid)
        else $error("result lost after load");

    // An accepted request is evaluated next
    a_accept_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_state == shgov_pkg::S_EVAL)
        else $error("accepted request not evaluated");

    // Division enters only through the multiply step
    a_div_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_state == shgov_pkg::S_DIV) |-> $past(r_state) == shgov_pkg::S_MUL)
        else $error("division started without scaled numerator");

endmodule

`default_nettype wire

// ===== hdl/secondary_core_hotplug_governor.sv =====
// Top level of the secondary core hotplug governor.
// Instantiates shgov_ctrl and shgov_dp; depends on shgov_pkg.
//
//  Channel   Direction  Handshake                  Payload
//  in        request    i_in_valid / o_in_ready    i_op, i_cur_freq_khz, i_core1_online,
//                                                  i_core0_idle_us, i_core0_wall_us
//  out       result     o_out_valid / i_out_ready  o_action, o_reschedule, o_long_delay,
//                                                  o_load_pct
//  cfg       write      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One request at a time, from acceptance to the next acceptance. The controller passes
// through EVAL and DONE when no load is computed, adds MUL when the wall delta is below
// the idle delta, and MUL, DIV (the 7-step restoring divider) and FIN otherwise.
// Synchronous active-low reset returns state and configuration registers to defaults.
// A stalled result holds the output register while the next request is accepted;
// that request waits for the register. Configuration writes are always ready.
`timescale 1ns / 1ps
`default_nettype none

module secondary_core_hotplug_governor (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic [shgov_pkg::OP_W-1:0]          i_op,
    input  wire logic [shgov_pkg::FREQ_W-1:0]        i_cur_freq_khz,
    input  wire logic                                i_core1_online,
    input  wire logic [63:0]                         i_core0_idle_us,
    input  wire logic [63:0]                         i_core0_wall_us,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic [shgov_pkg::ACT_W-1:0]              o_action,
    output logic                                     o_reschedule,
    output logic                                     o_long_delay,
    output logic [shgov_pkg::PCT_W-1:0]              o_load_pct,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [shgov_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [shgov_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    shgov_pkg::t_dp_cmd    cmd;
    shgov_pkg::t_dp_status status;

    assign o_cfg_ready = 1'b1;

    // Sequencer
    shgov_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Datapath
    shgov_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_cfg_we       (i_cfg_valid && o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_op           (i_op),
        .i_cur_freq_khz (i_cur_freq_khz),
        .i_core1_online (i_core1_online),
        .i_core0_idle_us(i_core0_idle_us),
        .i_core0_wall_us(i_core0_wall_us),
        .o_action       (o_action),
        .o_reschedule   (o_reschedule),
        .o_long_delay   (o_long_delay),
        .o_load_pct     (o_load_pct)
    );

endmodule

`default_nettype wire

// ===== tb/secondary_core_hotplug_governor_tb.sv =====
// Self-checking testbench for secondary_core_hotplug_governor: a directed table, then
// random samples and events under several settings, most with random idling on both sides.
// Depends on shgov_pkg and the RTL of the governor only.
`timescale 1ns / 1ps

module testbench;
    import shgov_pkg::*;

    localparam logic [OP_W-1:0]   OP_RSVD_6    = 3'd6;
    localparam logic [OP_W-1:0]   OP_RSVD_7    = 3'd7;
    localparam logic [FREQ_W-1:0] FREQ_MAX     = 22'h3F_FFFF;
    localparam logic [63:0]       CNT_ALL      = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam int                DRAIN_CYCLES = 16;
    localparam int                STALL_LIMIT  = 2000;

    // One governor decision
    typedef struct packed {
        t_action              action;
        logic                 resched;
        logic                 long_delay;
        logic [PCT_W-1:0]     load_pct;
    } t_hp_decision;

    // One request; a typed answer overrides the computed one when typed is set
    typedef struct packed {
        logic [OP_W-1:0]      op;
        logic [FREQ_W-1:0]    freq;
        logic                 online;
        logic [63:0]          idle;
        logic [63:0]          wall;
        logic                 typed;
        t_action              act;
        logic                 rs;
        logic                 ld;
        logic [PCT_W-1:0]     pct;
    } t_hp_req;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_in_valid     = 1'b0;
    logic [OP_W-1:0]       i_op           = '0;
    logic [FREQ_W-1:0]     i_cur_freq_khz = '0;
    logic                  i_core1_online = 1'b0;
    logic [63:0]           i_core0_idle_us = '0;
    logic [63:0]           i_core0_wall_us = '0;
    logic                  i_out_ready    = 1'b0;
    logic                  i_cfg_valid    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic [ACT_W-1:0]      o_action;
    logic                  o_reschedule;
    logic                  o_long_delay;
    logic [PCT_W-1:0]      o_load_pct;
    logic                  o_cfg_ready;

    // Predictor copy of the registers and the state
    logic [PCT_W-1:0]      lk_load_high = RST_LOAD_HIGH;
    logic                  lk_manual    = 1'b0;
    logic [FREQ_W-1:0]     lk_freq_low  = RST_FREQ_LOW;
    logic [FREQ_W-1:0]     lk_freq_high = RST_FREQ_HIGH;
    logic [FREQ_W-1:0]     gv_prev_freq = '0;
    logic [63:0]           gv_prev_idle = '0;
    logic [63:0]           gv_prev_wall = '0;
    logic                  gv_screen_off = 1'b0;
    logic                  gv_suspend   = 1'b0;
    logic                  gv_reboot    = 1'b0;
    logic                  gv_long      = 1'b0;

    t_hp_decision          pending_decisions [$];
    t_hp_req               cur_req      = '0;
    t_hp_req               dir_tab [0:25];
    int                    mismatch_cnt = 0;
    int                    quiet_cycles = 0;
    int                    tx_idle_pct  = 0;
    int                    rx_idle_pct  = 0;
    logic [63:0]           gen_idle     = '0;
    logic [63:0]           gen_wall     = '0;
    int                    gen_region   = 0;

    secondary_core_hotplug_governor dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_op            (i_op),
        .i_cur_freq_khz  (i_cur_freq_khz),
        .i_core1_online  (i_core1_online),
        .i_core0_idle_us (i_core0_idle_us),
        .i_core0_wall_us (i_core0_wall_us),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_action        (o_action),
        .o_reschedule    (o_reschedule),
        .o_long_delay    (o_long_delay),
        .o_load_pct      (o_load_pct),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Result receiver, stalls at random
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Next governor decision; updates the predictor state
    function automatic t_hp_decision decide_hotplug(input logic [OP_W-1:0] op,
                                                    input logic [FREQ_W-1:0] freq,
                                                    input logic online,
                                                    input logic [63:0] idle,
                                                    input logic [63:0] wall);
        t_hp_decision r;
        logic [31:0]  d_idle;
        logic [31:0]  d_wall;
        logic [63:0]  scaled;
        r = '0;
        r.action = ACT_NONE;
        case (op)
            OP_SAMPLE: begin
                // screen off with core one down: sample dropped, nothing scheduled
                if (!(gv_screen_off && !online)) begin
                    r.resched = 1'b1;
                    if (!(lk_manual || gv_suspend || gv_reboot)) begin
                        if (freq <= lk_freq_low && gv_prev_freq <= lk_freq_low) begin
                            if (online)
                                r.action = ACT_OFFLINE;
                            gv_long = 1'b0;
                        end else if (freq > lk_freq_high && gv_prev_freq > lk_freq_high) begin
                            if (!online) begin
                                d_idle = 32'(idle - gv_prev_idle);
                                d_wall = 32'(wall - gv_prev_wall);
                                gv_prev_idle = idle;
                                gv_prev_wall = wall;
                                if (d_wall < d_idle) begin
                                    gv_long = 1'b0;
                                end else begin
                                    if (d_wall != 0) begin
                                        scaled = (64'(d_wall - d_idle) * 64'd100) / 64'(d_wall);
                                        r.load_pct = scaled[PCT_W-1:0];
                                    end
                                    if (r.load_pct > lk_load_high) begin
                                        r.action = ACT_ONLINE;
                                        gv_long = 1'b1;
                                    end else begin
                                        gv_long = 1'b0;
                                    end
                                end
                            end
                        end else begin
                            gv_long = online;
                        end
                    end
                    // frequency is recorded even when locked
                    gv_prev_freq = freq;
                end
            end
            OP_SCREEN_OFF: gv_screen_off = 1'b1;
            OP_SCREEN_ON: begin
                gv_screen_off = 1'b0;
                r.resched = 1'b1;
            end
            OP_SUSPEND: gv_suspend = 1'b1;
            OP_RESUME: gv_suspend = 1'b0;
            OP_REBOOT: gv_reboot = 1'b1;
            default: ;
        endcase
        r.long_delay = gv_long;
        return r;
    endfunction

    // Handshake monitor: predicts accepted requests, checks accepted results
    always @(posedge i_clk) begin : scoreboard
        t_hp_decision want;
        if (i_rst_n) begin
            // a result accepted now belongs to an older request
            if (o_out_valid && i_out_ready) begin
                if (pending_decisions.size() == 0) begin
                    $error("result with no request outstanding");
                    mismatch_cnt++;
                end else begin
                    want = pending_decisions.pop_front();
                    if (o_action !== want.action) begin
                        $error("action: expected %0d, got %0d", want.action, o_action);
                        mismatch_cnt++;
                    end
                    if (o_reschedule !== want.resched) begin
                        $error("reschedule: expected %0d, got %0d", want.resched, o_reschedule);
                        mismatch_cnt++;
                    end
                    if (o_long_delay !== want.long_delay) begin
                        $error("long_delay: expected %0d, got %0d", want.long_delay,
                               o_long_delay);
                        mismatch_cnt++;
                    end
                    if (o_load_pct !== want.load_pct) begin
                        $error("load_pct: expected %0d, got %0d", want.load_pct, o_load_pct);
                        mismatch_cnt++;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_LOAD_HIGH:   lk_load_high = i_cfg_data[PCT_W-1:0];
                    CFG_MANUAL_LOCK: lk_manual    = i_cfg_data[0];
                    CFG_FREQ_LOW:    lk_freq_low  = i_cfg_data[FREQ_W-1:0];
                    CFG_FREQ_HIGH:   lk_freq_high = i_cfg_data[FREQ_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                want = decide_hotplug(i_op, i_cur_freq_khz, i_core1_online,
                                      i_core0_idle_us, i_core0_wall_us);
                if (cur_req.typed)
                    want = '{cur_req.act, cur_req.rs, cur_req.ld, cur_req.pct};
                pending_decisions.push_back(want);
            end
        end
    end

    // Watchdog: no handshake of any kind for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $error("no handshake for %0d cycles", quiet_cycles);
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Present one request, with a random gap first; returns at acceptance
    task automatic send_req(input t_hp_req rq);
        int gap;
        gap = 0;
        while (gap < 30 && $urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_op            <= rq.op;
        i_cur_freq_khz  <= rq.freq;
        i_core1_online  <= rq.online;
        i_core0_idle_us <= rq.idle;
        i_core0_wall_us <= rq.wall;
        cur_req         <= rq;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Stop sending and let every outstanding decision come back
    task automatic drain;
        i_in_valid <= 1'b0;
        // one edge first, so the last accepted request is already queued
        @(posedge i_clk);
        while (pending_decisions.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic put_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Reprogram all four registers while the block is idle
    task automatic write_regs(input int unsigned load_high, input logic manual,
                              input int unsigned lo_khz, input int unsigned hi_khz);
        drain;
        put_reg(CFG_LOAD_HIGH, CFG_DATA_W'(load_high));
        put_reg(CFG_MANUAL_LOCK, CFG_DATA_W'(manual));
        put_reg(CFG_FREQ_LOW, CFG_DATA_W'(lo_khz));
        put_reg(CFG_FREQ_HIGH, CFG_DATA_W'(hi_khz));
        i_cfg_valid <= 1'b0;
    endtask

    // Random traffic: mostly samples in sticky frequency bands with growing counters
    task automatic gen_burst(input int n, input int unsigned lo_khz, input int unsigned hi_khz);
        t_hp_req     rq;
        int          pick;
        int          kind;
        logic [63:0] d_idle;
        logic [63:0] d_wall;
        for (int i = 0; i < n; i++) begin
            rq = '0;
            rq.act = ACT_NONE;
            pick = $urandom_range(199);
            if (pick < 3)       rq.op = OP_SCREEN_OFF;
            else if (pick < 12) rq.op = OP_SCREEN_ON;
            else if (pick < 15) rq.op = OP_SUSPEND;
            else if (pick < 24) rq.op = OP_RESUME;
            else if (pick < 25) rq.op = OP_RSVD_6;
            else if (pick < 26) rq.op = OP_RSVD_7;
            else                rq.op = OP_SAMPLE;

            // frequency band: 0 low, 1 anywhere, 2 high
            if ($urandom_range(3) == 0)
                gen_region = $urandom_range(2);
            case (gen_region)
                0: rq.freq = ($urandom_range(3) == 0) ? FREQ_W'(lo_khz)
                                                      : FREQ_W'($urandom_range(lo_khz));
                2: begin
                    if (hi_khz >= FREQ_MAX)
                        rq.freq = FREQ_MAX;
                    else if ($urandom_range(3) == 0)
                        rq.freq = FREQ_W'(hi_khz + 1);
                    else
                        rq.freq = FREQ_W'($urandom_range(FREQ_MAX, hi_khz + 1));
                end
                default: rq.freq = FREQ_W'($urandom_range(FREQ_MAX));
            endcase
            rq.online = ($urandom_range(99) < 35);

            // counter progress: normal, zero, negative, wide and wrapping deltas
            d_idle = '0;
            d_wall = '0;
            kind = $urandom_range(19);
            case (kind)
                0: begin
                    gen_idle = {$urandom, $urandom};
                    gen_wall = {$urandom, $urandom};
                end
                1: ;
                2: begin
                    d_wall = 64'($urandom_range(5000));
                    d_idle = d_wall + 64'($urandom_range(5000, 1));
                end
                3: begin
                    d_wall = 64'($urandom);
                    d_idle = 64'($urandom_range(32'(d_wall)));
                end
                4: begin
                    d_wall = {29'd0, 3'($urandom_range(7)), $urandom};
                    d_idle = {32'd0, $urandom};
                end
                default: begin
                    d_wall = 64'($urandom_range(500000, 1));
                    d_idle = 64'($urandom_range(32'(d_wall)));
                end
            endcase
            gen_idle = gen_idle + d_idle;
            gen_wall = gen_wall + d_wall;
            rq.idle = gen_idle;
            rq.wall = gen_wall;
            send_req(rq);
        end
    endtask

    initial begin : stimulus
        t_hp_req     rq;
        int unsigned lo_khz;
        int unsigned hi_khz;
        int unsigned load_high;

        // Directed table, run under the reset register values
        // fields: op, freq, online, idle, wall, typed, action, resched, long, load
        dir_tab[0]  = '{OP_SAMPLE, 22'd0, 1'b1, 64'd0, 64'd0, 1'b1, ACT_OFFLINE, 1'b1, 1'b0, 7'd0};
        dir_tab[1]  = '{OP_SAMPLE, 22'd0, 1'b0, 64'd0, 64'd0, 1'b1, ACT_NONE, 1'b1, 1'b0, 7'd0};
        // first high sample only records the frequency
        dir_tab[2]  = '{OP_SAMPLE, FREQ_MAX, 1'b0, 64'd100, 64'd1000,
                        1'b1, ACT_NONE, 1'b1, 1'b0, 7'd0};
        dir_tab[3]  = '{OP_SAMPLE, FREQ_MAX, 1'b0, 64'd100, 64'd1000,
                        1'b1, ACT_ONLINE, 1'b1, 1'b1, 7'd90};
        // both cores up: delay kept
        dir_tab[4]  = '{OP_SAMPLE, FREQ_MAX, 1'b1, 64'd0, 64'd0, 1'b1, ACT_NONE, 1'b1, 1'b1, 7'd0};
        // idle delta above wall delta
        dir_tab[5]  = '{OP_SAMPLE, FREQ_MAX, 1'b0, 64'd600, 64'd1200,
                        1'b1, ACT_NONE, 1'b1, 1'b0, 7'd0};
        // zero wall delta
        dir_tab[6]  = '{OP_SAMPLE, FREQ_MAX, 1'b0, 64'd600, 64'd1200,
                        1'b1, ACT_NONE, 1'b1, 1'b0, 7'd0};
        // full 32-bit wall delta, no idle: load 100
        dir_tab[7]  = '{OP_SAMPLE, FREQ_MAX, 1'b0, 64'd600, 64'h0000_0001_0000_04AF,
                        1'b1, ACT_ONLINE, 1'b1, 1'b1, 7'd100};
        dir_tab[8]  = '{OP_SAMPLE, FREQ_MAX, 1'b0, CNT_ALL, CNT_ALL,
                        1'b0, ACT_NONE, 1'b0, 1'b0, 7'd0};
        dir_tab[9]  = '{OP_SAMPLE, FREQ_MAX, 1'b0, 64'h0000_0001_0000_0004,
                        64'h8000_0000_0000_0000, 1'b0, ACT_NONE, 1'b0, 1'b0, 7'd0};
        dir_tab[10] = '{OP_SAMPLE, 22'd300000, 1'b1, 64'd0, 64'd0,
                        1'b0, ACT_NONE, 1'b0, 1'b0, 7'd0};
        dir_tab[11] = '{OP_SCREEN_OFF, 22'd0, 1'b0, 64'd0, 64'd0,
                        1'b0, ACT_NONE, 1'b0, 1'b0, 7'd0};
        // screen off with one core: dropped
        dir_tab[12] = '{OP_SAMPLE, 22'd0, 1'b0, 64'd0, 64'd0, 1'b0, ACT_NONE, 1'b0, 1'b0, 7'd0};
        dir_tab[13] = '{OP_SAMPLE, 22'd0, 1'b1, 64'd0, 64'd0, 1'b0, ACT_NONE, 1'b0, 1'b0, 7'd0};
        dir_tab[14] = '{OP_SCREEN_ON, CNT_ALL[21:0], 1'b1, CNT_ALL, CNT_ALL,
                        1'b0, ACT_NONE, 1'b0, 1'b0, 7'd0};
        dir_tab[15] = '{OP_SUSPEND, 22'd0, 1'b0, 64'd0, 64'd0, 1'b0, ACT_NONE, 1'b0, 1'b0, 7'd0};
        // locked sample still records the frequency
        dir_tab[16] = '{OP_SAMPLE, FREQ_MAX, 1'b0, 64'd5, 64'd9, 1'b0, ACT_NONE, 1'b0, 1'b0, 7'd0};
        dir_tab[17] = '{OP_SUSPEND, 22'd0, 1'b0, 64'd0, 64'd0, 1'b0, ACT_NONE, 1'b0, 1'b0, 7'd0};
        dir_tab[18] = '{OP_RESUME, 22'd0, 1'b0, 64'd0, 64'd0, 1'b0, ACT_NONE, 1'b0, 1'b0, 7'd0};
        dir_tab[19] = '{OP_SAMPLE, FREQ_MAX, 1'b0, 64'h0000_0001_0000_0010,
                        64'h8000_0000_0000_1000, 1'b0, ACT_NONE, 1'b0, 1'b0, 7'd0};
        dir_tab[20] = '{OP_RSVD_6, FREQ_MAX, 1'b1, CNT_ALL, CNT_ALL,
                        1'b0, ACT_NONE, 1'b0, 1'b0, 7'd0};
        dir_tab[21] = '{OP_RSVD_7, 22'd0, 1'b0, 64'd0, 64'd0, 1'b0, ACT_NONE, 1'b0, 1'b0, 7'd0};
        // exactly at the low threshold
        dir_tab[22] = '{OP_SAMPLE, 22'd200000, 1'b1, 64'd0, 64'd0,
                        1'b0, ACT_NONE, 1'b0, 1'b0, 7'd0};
        dir_tab[23] = '{OP_SAMPLE, 22'd200000, 1'b1, 64'd0, 64'd0,
                        1'b0, ACT_NONE, 1'b0, 1'b0, 7'd0};
        // at and just over the high threshold
        dir_tab[24] = '{OP_SAMPLE, 22'd500000, 1'b0, 64'd10, 64'd20,
                        1'b0, ACT_NONE, 1'b0, 1'b0, 7'd0};
        dir_tab[25] = '{OP_SAMPLE, 22'd500001, 1'b0, 64'd10, 64'd20,
                        1'b0, ACT_NONE, 1'b0, 1'b0, 7'd0};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sender lightly idle, receiver mostly stalled
        tx_idle_pct = 18;
        rx_idle_pct = 65;
        for (int i = 0; i < 26; i++)
            send_req(dir_tab[i]);
        write_regs(0, 1'b0, 0, 0);
        gen_burst(280, 0, 0);
        write_regs(100, 1'b1, 200000, 500000);
        gen_burst(100, 200000, 500000);

        // Sender mostly idle, receiver lightly stalled
        tx_idle_pct = 65;
        rx_idle_pct = 18;
        write_regs(73, 1'b0, FREQ_MAX, FREQ_MAX);
        gen_burst(280, FREQ_MAX, FREQ_MAX);
        lo_khz    = $urandom_range(2000000, 1);
        hi_khz    = $urandom_range(FREQ_MAX, lo_khz + 1);
        load_high = $urandom_range(99, 1);
        write_regs(load_high, 1'b0, lo_khz, hi_khz);
        gen_burst(280, lo_khz, hi_khz);

        // No idling on either side
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_regs(50, 1'b0, 200000, 500000);
        gen_burst(280, 200000, 500000);
        // low threshold above the high one
        load_high = $urandom_range(100);
        write_regs(load_high, 1'b0, 3000000, 1000000);
        gen_burst(280, 3000000, 1000000);

        // Reboot lock holds until reset, so it comes last
        rq = '0;
        rq.op = OP_REBOOT;
        rq.act = ACT_NONE;
        send_req(rq);
        gen_burst(30, 200000, 500000);

        drain;
        if (mismatch_cnt == 0 && pending_decisions.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
